### rtl/irfd_pkg.sv
// irfd_pkg: shared constants for the ir remote frame decoder
// register indexes, reset values, request kinds, command codes and action codes
// no dependencies
package irfd_pkg;

    localparam int FRAME_SLOTS = 50;

    localparam int TICK_W  = 17;
    localparam int HALF_W  = 16;
    localparam int SLOT_W  = 6;
    localparam int CMD_W   = 8;
    localparam int ACT_W   = 3;
    localparam int PIN_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [HALF_W-1:0] LEADER_MIN_RST = 16'd10000;
    localparam logic [HALF_W-1:0] LEADER_MAX_RST = 16'd15000;
    localparam logic [HALF_W-1:0] ONE_MIN_RST    = 16'd2000;
    localparam logic [HALF_W-1:0] ONE_MAX_RST    = 16'd2300;
    localparam logic [SLOT_W-1:0] CMD_SLOT_RST   = 6'd17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEADER_MIN = 3'd0,
        CFG_LEADER_MAX = 3'd1,
        CFG_ONE_MIN    = 3'd2,
        CFG_ONE_MAX    = 3'd3,
        CFG_CMD_SLOT   = 3'd4
    } t_cfg_idx;

    // request kinds carried in tuser
    localparam logic FUNC_EDGE    = 1'b0;
    localparam logic FUNC_TIMEOUT = 1'b1;

    localparam logic [CMD_W-1:0] CODE_STOP   = 8'd69;
    localparam logic [CMD_W-1:0] CODE_VOL_UP = 8'd18;
    localparam logic [CMD_W-1:0] CODE_VOL_UP_ALT = 8'd17;
    localparam logic [CMD_W-1:0] CODE_VOL_DN = 8'd26;
    localparam logic [CMD_W-1:0] CODE_OK     = 8'd6;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_STOP    = 3'd1,
        ACT_VOL_UP  = 3'd2,
        ACT_VOL_DN  = 3'd3,
        ACT_OK      = 3'd4
    } t_action;

    localparam logic [PIN_W-1:0] PINS_STOP   = 3'b000;
    localparam logic [PIN_W-1:0] PINS_VOL_UP = 3'b001;
    localparam logic [PIN_W-1:0] PINS_VOL_DN = 3'b010;
    localparam logic [PIN_W-1:0] PINS_OK     = 3'b100;

endpackage

### rtl/ir_remote_frame_decoder_unit.sv
// ir_remote_frame_decoder_unit: decodes ir remote frames from edge and timeout events
// depends on irfd_pkg
// an input request passes the input register and the result register, in that order, to become a result request
// throughput: one request per cycle while the result side is ready
// edge events update frame state only; a timeout of a started frame gives one result
// reset (synchronous, active low) restores default windows and clears all frame state
module ir_remote_frame_decoder_unit
    import irfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,  // [16:0] elapsed_ticks
    input  logic                  s_axis_tuser,  // [0] func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,  // [7:0] command, [10:8] action, [13:11] pin_pattern
    output logic                  m_axis_tuser,  // [0] frame_valid
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [HALF_W-1:0] r_leader_min, r_leader_max, r_one_min, r_one_max;
    logic [SLOT_W-1:0] r_cmd_slot;

    logic              r_in_valid;
    logic              r_in_func;
    logic [TICK_W-1:0] r_in_ticks;

    logic              r_frame_started, n_frame_started;
    logic [SLOT_W-1:0] r_edge_count, n_edge_count;
    logic [HALF_W-1:0] r_leader_interval, n_leader_interval;
    logic [CMD_W-1:0]  r_bit_marks, n_bit_marks;
    logic [PIN_W-1:0]  r_pins_held, n_pins_held;

    logic              r_out_valid;
    logic              r_out_frame_valid, n_out_frame_valid;
    logic [CMD_W-1:0]  r_out_cmd, n_out_cmd;
    logic [ACT_W-1:0]  r_out_act, n_out_act;

    logic              w_adv;
    logic              w_produce;
    logic [HALF_W-1:0] w_half;
    logic [SLOT_W-1:0] w_bit_idx;
    logic              w_is_one;

    assign o_cfg_ready   = 1'b1;
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_produce     = w_adv && r_in_func && r_frame_started;
    assign w_half        = r_in_ticks[TICK_W-1:1];
    assign w_bit_idx     = r_edge_count - r_cmd_slot;
    assign w_is_one      = (w_half >= r_one_min) && (w_half <= r_one_max);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader_min <= LEADER_MIN_RST;
            r_leader_max <= LEADER_MAX_RST;
            r_one_min    <= ONE_MIN_RST;
            r_one_max    <= ONE_MAX_RST;
            r_cmd_slot   <= CMD_SLOT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LEADER_MIN: r_leader_min <= i_cfg_data;
                CFG_LEADER_MAX: r_leader_max <= i_cfg_data;
                CFG_ONE_MIN:    r_one_min    <= i_cfg_data;
                CFG_ONE_MAX:    r_one_max    <= i_cfg_data;
                CFG_CMD_SLOT:   r_cmd_slot   <= i_cfg_data[SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func  <= s_axis_tuser;
            r_in_ticks <= s_axis_tdata[TICK_W-1:0];
        end
    end

    always_comb begin
        n_frame_started   = r_frame_started;
        n_edge_count      = r_edge_count;
        n_leader_interval = r_leader_interval;
        n_bit_marks       = r_bit_marks;
        n_pins_held       = r_pins_held;
        n_out_frame_valid = 1'b0;
        n_out_cmd         = '0;
        n_out_act         = ACT_NONE;
        if (w_adv) begin
            if (!r_in_func) begin
                if (!r_frame_started) begin
                    n_frame_started = 1'b1;
                end else if (r_edge_count < SLOT_W'(FRAME_SLOTS)) begin
                    if (r_edge_count == '0) begin
                        n_leader_interval = w_half;
                    end
                    if ((r_edge_count >= r_cmd_slot) && (w_bit_idx < SLOT_W'(CMD_W))) begin
                        n_bit_marks[w_bit_idx[2:0]] = w_is_one;
                    end
                    n_edge_count = r_edge_count + 1'b1;
                end
            end else if (r_frame_started) begin
                n_out_frame_valid = (r_leader_interval >= r_leader_min) &&
                                    (r_leader_interval <= r_leader_max);
                if (n_out_frame_valid) begin
                    n_out_cmd = r_bit_marks;
                    case (r_bit_marks)
                        CODE_STOP: begin
                            n_out_act   = ACT_STOP;
                            n_pins_held = PINS_STOP;
                        end
                        CODE_VOL_UP, CODE_VOL_UP_ALT: begin
                            n_out_act   = ACT_VOL_UP;
                            n_pins_held = PINS_VOL_UP;
                        end
                        CODE_VOL_DN: begin
                            n_out_act   = ACT_VOL_DN;
                            n_pins_held = PINS_VOL_DN;
                        end
                        CODE_OK: begin
                            n_out_act   = ACT_OK;
                            n_pins_held = PINS_OK;
                        end
                        default: ;
                    endcase
                end
                n_frame_started   = 1'b0;
                n_leader_interval = '0;
                n_edge_count      = '0;
            end
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_started   <= 1'b0;
            r_edge_count      <= '0;
            r_leader_interval <= '0;
            r_bit_marks       <= '0;
            r_pins_held       <= '0;
        end else begin
            r_frame_started   <= n_frame_started;
            r_edge_count      <= n_edge_count;
            r_leader_interval <= n_leader_interval;
            r_bit_marks       <= n_bit_marks;
            r_pins_held       <= n_pins_held;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_produce) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            r_out_frame_valid <= n_out_frame_valid;
            r_out_cmd         <= n_out_cmd;
            r_out_act         <= n_out_act;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_frame_valid;
    assign m_axis_tdata  = {2'b00, r_pins_held, r_out_act, r_out_cmd};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_count <= SLOT_W'(FRAME_SLOTS))
        else $error("edge count past last slot");

    a_timeout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_func) |=> (r_edge_count == '0 && !r_frame_started &&
                                  r_leader_interval == '0))
        else $error("timeout left frame state");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_produce |=> m_axis_tvalid)
        else $error("timeout of started frame gave no result");

    a_leader_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_leader_interval != '0) |-> r_frame_started)
        else $error("leader held without a started frame");

    a_invalid_zero_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[7:0] == '0 &&
                                              m_axis_tdata[10:8] == ACT_NONE))
        else $error("invalid frame carries a command");

endmodule
